// ===== design/afe_pkg.sv =====
// Shared types, widths and constants of the acoustic frame feature extractor.
package afe_pkg;

	// Field and accumulator widths.
	localparam int FL_W = 13;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W = 16;
	localparam int TOT_W = 43;
	localparam int MAG_ACC_W = 28;
	localparam int IMAG_W = 41;
	localparam int CC_W = 13;

	// Divider and logarithm unit widths.
	localparam int DIV_W = 64;
	localparam int DEN_W = 44;
	localparam int CNT_W = 6;
	localparam int LOG_W = 44;
	localparam int MANT_W = 31;
	localparam int LINT_W = 6;
	localparam int LFRAC_W = 16;
	localparam int LOGV_W = LINT_W + LFRAC_W;

	// Defaults.
	localparam int MAX_FRAME_DEF = 4096;
	localparam logic [FL_W-1:0] FRAME_LEN_RST = 13'd256;

	// Division step counts (quotient bits).
	localparam int DIV_STEPS_MEAN = 44;
	localparam int DIV_STEPS_CEN = 24;
	localparam int DIV_STEPS_PH = 30;
	localparam int DIV_STEPS_DMP = 60;

	// Feature constants.
	localparam int EPS = 4;
	localparam int CEN_BASE = 5600;
	localparam int CEN_SCALE = 122400;
	localparam int CEN_HALF = 8388608;
	localparam int CEN_MAX = 128000;
	localparam int PH_ONE = 65536;
	localparam int LN2_X24 = 1090226;
	localparam int DEC_ROUND = 2097152;
	localparam int DEC_BASE = 6144;
	localparam int DEC_SILENT = 36864;
	localparam int DEC_MIN = 4096;
	localparam int DEC_MAX = 49152;
	localparam int DMP_MIN = 1311;
	localparam int DMP_MAX = 64225;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ACC1,
		ST_ACC2,
		ST_MEAN,
		ST_CMUL,
		ST_CLD,
		ST_CEN,
		ST_CSC,
		ST_CFIN,
		ST_PH,
		ST_DMP,
		ST_LNORM,
		ST_LSQ,
		ST_LUPD,
		ST_DMUL,
		ST_DFIN,
		ST_OUT
	} afe_state_t;

	// Divider start request.
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] cnt;
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} afe_div_ctl_t;

	// Divider status.
	typedef struct packed {
		logic             last;
		logic [DIV_W-1:0] quot;
	} afe_div_sts_t;

endpackage

// ===== design/afe_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module afe_div import afe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  afe_div_ctl_t ctl,
	output afe_div_sts_t sts
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] a_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_sh;
	logic [DIV_W-1:0] rem_nx;
	logic [DIV_W-1:0] a_nx;
	logic [DIV_W-1:0] den_ext;
	logic             ge;

	// One shift, compare and subtract step.
	always_comb begin
		den_ext = DIV_W'(den_q);
		rem_sh = {rem_q[DIV_W-2:0], a_q[DIV_W-1]};
		ge = (rem_sh >= den_ext);
		rem_nx = ge ? (rem_sh - den_ext) : rem_sh;
		a_nx = {a_q[DIV_W-2:0], ge};
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= ctl.cnt;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Remainder, dividend and quotient shift registers.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= ctl.rem;
			a_q <= ctl.num;
			den_q <= ctl.den;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			a_q <= a_nx;
		end
	end

	assign sts.last = (cnt_q == CNT_W'(1));
	assign sts.quot = a_nx;

endmodule

// ===== design/acoustic_frame_feature_extractor_unit.sv =====
// Top level of the acoustic frame feature extractor.
//
// Samples enter on the input channel (in_valid, in_stall, sample) and are
// accepted when in_valid is high and in_stall is low. Each sample passes
// through the accept state and two accumulate states; one 32x32 multiplier
// forms the squared magnitude and the index-weighted magnitude.
// The frame_length register is written through cfg_wr_en and cfg_wr_data.
// On the last sample of a frame a sequencer computes the five features with
// the same multiplier and one restoring divider (one quotient bit a cycle)
// plus a repeated-squaring log2 (a multiply state and an update state per bit).
// When the late energy is 4 or less the logarithms are skipped and the
// decay is a fixed value; otherwise each 44-bit log2 argument is first
// normalized by shifting out its leading zeros one at a time.
// The result leaves through an output register (out_valid, out_stall, and
// the feature ports). While a result waits under out_stall the block keeps
// taking samples of the next frame; it only holds at the end of that frame.
// Reset clears all accumulators, drops out_valid and sets frame_length to 256.
module acoustic_frame_feature_extractor_unit import afe_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [FL_W-1:0]            cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [30:0]                mean_energy,
	output logic [16:0]                centroid_hz_x16,
	output logic [16:0]                stability_q16,
	output logic [15:0]                decay_ms_q10,
	output logic [15:0]                damping_q16
);

	afe_state_t state_q, state_d;
	afe_div_ctl_t div_ctl;
	afe_div_sts_t div_sts;

	// Configuration and frame accumulators.
	logic [FL_W-1:0]      fl_q;
	logic [FL_W-1:0]      n_w;
	logic [FL_W-1:0]      idx_q;
	logic                 prev_neg_q;
	logic [TOT_W-1:0]     tot_q;
	logic [TOT_W-1:0]     early_q;
	logic [MAG_ACC_W-1:0] mag_acc_q;
	logic [IMAG_W-1:0]    imag_q;
	logic [CC_W-1:0]      cc_q;

	// Sample and multiplier.
	logic                 neg_in;
	logic [MAG_W-1:0]     mag_in;
	logic [MAG_W-1:0]     mag_q;
	logic                 neg_q;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          prod_q;

	// Intermediate features.
	logic [30:0]          mean_q;
	logic [23:0]          qc_q;
	logic [16:0]          cen_q;
	logic [16:0]          ph_q;
	logic [15:0]          dmp_q;
	logic [15:0]          dec_q;

	// Logarithm unit.
	logic [LOG_W-1:0]     w_q;
	logic [5:0]           sh_q;
	logic [MANT_W-1:0]    m_q;
	logic [LINT_W-1:0]    r_int_q;
	logic [LFRAC_W-1:0]   r_frac_q;
	logic [LOGV_W-1:0]    r1_q;
	logic [3:0]           k_q;
	logic                 lsel_q;
	logic signed [LOGV_W:0] d_q;

	// Output register.
	logic                 out_valid_q;
	logic [30:0]          mean_o_q;
	logic [16:0]          cen_o_q;
	logic [16:0]          ph_o_q;
	logic [15:0]          dec_o_q;
	logic [15:0]          dmp_o_q;

	// Combinational helpers.
	logic                 frame_end;
	logic                 early_en;
	logic [FL_W:0]        idx_inc;
	logic [FL_W+1:0]      idx_tri;
	logic [TOT_W-1:0]     late_w;
	logic                 late_small;
	logic                 slot_free;
	logic [LOG_W-1:0]     early_eps;
	logic [LOG_W-1:0]     late_eps;
	logic [DEN_W-1:0]     tot_eps;
	logic [43:0]          num_mean;
	logic [29:0]          num_ph;
	logic [59:0]          num_dmp;
	logic [41:0]          cen_t;
	logic [18:0]          cen_s;
	logic [16:0]          cen_w;
	logic [16:0]          ph_w;
	logic [15:0]          dmp_w;
	logic [31:0]          m2;
	logic [LFRAC_W-1:0]   r_frac_nx;
	logic [LOGV_W-1:0]    r_full;
	logic signed [LOGV_W:0] d_w;
	logic [LOGV_W:0]      d_abs;
	logic signed [45:0]   pm;
	logic signed [45:0]   ps;
	logic signed [45:0]   dv;
	logic [15:0]          dec_w;

	// Effective frame length.
	always_comb begin
		if (fl_q == '0) begin
			n_w = FL_W'(1);
		end else if (int'(fl_q) > MAX_FRAME) begin
			n_w = FL_W'(MAX_FRAME);
		end else begin
			n_w = fl_q;
		end
	end

	// Sample magnitude and frame position tests.
	always_comb begin
		neg_in = sample[SAMPLE_W-1];
		mag_in = neg_in ? MAG_W'(-sample) : MAG_W'(sample);
		idx_inc = {1'b0, idx_q} + (FL_W+1)'(1);
		idx_tri = {idx_inc, 1'b0} + {1'b0, idx_inc};
		early_en = (idx_tri <= (FL_W+2)'(n_w));
		frame_end = (idx_inc >= (FL_W+1)'(n_w));
		late_w = tot_q - early_q;
		late_small = (late_w <= TOT_W'(EPS));
		slot_free = !out_valid_q || !out_stall;
		early_eps = LOG_W'(early_q) + LOG_W'(EPS);
		late_eps = LOG_W'(late_w) + LOG_W'(EPS);
		tot_eps = DEN_W'(tot_q) + DEN_W'(EPS);
		num_mean = 44'(tot_q) + 44'(n_w >> 1);
		num_ph = 30'({cc_q, 16'b0}) + 30'(n_w >> 1);
		num_dmp = 60'({late_w, 16'b0}) + 60'(tot_eps >> 1);
	end

	// Feature finishing arithmetic.
	always_comb begin
		cen_t = prod_q[41:0] + 42'(CEN_HALF);
		cen_s = 19'(cen_t[41:24]) + 19'(CEN_BASE);
		if (mag_acc_q == '0) begin
			cen_w = '0;
		end else if (cen_s > 19'(CEN_MAX)) begin
			cen_w = 17'(CEN_MAX);
		end else begin
			cen_w = cen_s[16:0];
		end
		if (div_sts.quot[29:0] >= 30'(PH_ONE)) begin
			ph_w = '0;
		end else begin
			ph_w = 17'(30'(PH_ONE) - div_sts.quot[29:0]);
		end
		if (div_sts.quot[59:0] < 60'(DMP_MIN)) begin
			dmp_w = 16'(DMP_MIN);
		end else if (div_sts.quot[59:0] > 60'(DMP_MAX)) begin
			dmp_w = 16'(DMP_MAX);
		end else begin
			dmp_w = div_sts.quot[15:0];
		end
	end

	// Logarithm update and decay finishing.
	always_comb begin
		m2 = prod_q[61:30];
		r_frac_nx = r_frac_q | (m2[31] ? (LFRAC_W'(1) << k_q) : '0);
		r_full = {r_int_q, r_frac_nx};
		d_w = $signed({1'b0, r1_q}) - $signed({1'b0, r_full});
		d_abs = d_q[LOGV_W] ? (LOGV_W+1)'(-d_q) : (LOGV_W+1)'(d_q);
		pm = $signed({2'b0, prod_q[43:0]});
		ps = d_q[LOGV_W] ? -pm : pm;
		dv = ((ps + 46'sd2097152) >>> 22) + 46'(DEC_BASE);
		if (dv < 46'(DEC_MIN)) begin
			dec_w = 16'(DEC_MIN);
		end else if (dv > 46'(DEC_MAX)) begin
			dec_w = 16'(DEC_MAX);
		end else begin
			dec_w = dv[15:0];
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_a = 32'(mag_in);
				mul_b = 32'(mag_in);
			end
			ST_ACC1: begin
				mul_a = 32'(idx_q);
				mul_b = 32'(mag_q);
			end
			ST_CMUL: begin
				mul_a = 32'(n_w);
				mul_b = 32'(mag_acc_q);
			end
			ST_CSC: begin
				mul_a = 32'(CEN_SCALE);
				mul_b = 32'(qc_q);
			end
			ST_LSQ: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			ST_DMUL: begin
				mul_a = 32'(d_abs);
				mul_b = 32'(LN2_X24);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and divider requests.
	always_comb begin
		state_d = state_q;
		div_ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_ACC1;
			end
			ST_ACC1: begin
				state_d = ST_ACC2;
			end
			ST_ACC2: begin
				if (frame_end) begin
					div_ctl.start = 1'b1;
					div_ctl.cnt = CNT_W'(DIV_STEPS_MEAN);
					div_ctl.num = {num_mean, 20'b0};
					div_ctl.den = DEN_W'(n_w);
					state_d = ST_MEAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MEAN: begin
				if (div_sts.last) state_d = ST_CMUL;
			end
			ST_CMUL: begin
				state_d = ST_CLD;
			end
			ST_CLD: begin
				div_ctl.start = 1'b1;
				div_ctl.cnt = CNT_W'(DIV_STEPS_CEN);
				div_ctl.rem = DIV_W'(imag_q);
				div_ctl.den = prod_q[DEN_W-1:0];
				state_d = ST_CEN;
			end
			ST_CEN: begin
				if (div_sts.last) state_d = ST_CSC;
			end
			ST_CSC: begin
				state_d = ST_CFIN;
			end
			ST_CFIN: begin
				div_ctl.start = 1'b1;
				div_ctl.cnt = CNT_W'(DIV_STEPS_PH);
				div_ctl.num = {num_ph, 34'b0};
				div_ctl.den = DEN_W'(n_w);
				state_d = ST_PH;
			end
			ST_PH: begin
				if (div_sts.last) begin
					div_ctl.start = 1'b1;
					div_ctl.cnt = CNT_W'(DIV_STEPS_DMP);
					div_ctl.num = {num_dmp, 4'b0};
					div_ctl.den = tot_eps;
					state_d = ST_DMP;
				end
			end
			ST_DMP: begin
				if (div_sts.last) state_d = late_small ? ST_OUT : ST_LNORM;
			end
			ST_LNORM: begin
				if (w_q[LOG_W-1]) state_d = ST_LSQ;
			end
			ST_LSQ: begin
				state_d = ST_LUPD;
			end
			ST_LUPD: begin
				if (k_q == '0) begin
					state_d = lsel_q ? ST_DMUL : ST_LNORM;
				end else begin
					state_d = ST_LSQ;
				end
			end
			ST_DMUL: begin
				state_d = ST_DFIN;
			end
			ST_DFIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Configuration, accumulators and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= FRAME_LEN_RST;
			idx_q <= '0;
			prev_neg_q <= 1'b0;
			tot_q <= '0;
			early_q <= '0;
			mag_acc_q <= '0;
			imag_q <= '0;
			cc_q <= '0;
			lsel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) fl_q <= cfg_wr_data;
			// A new result replaces one that leaves in the same cycle.
			if (state_q == ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_ACC1) begin
				tot_q <= tot_q + TOT_W'(prod_q[31:0]);
				if (early_en) early_q <= early_q + TOT_W'(prod_q[31:0]);
				mag_acc_q <= mag_acc_q + MAG_ACC_W'(mag_q);
				if (idx_q != '0 && neg_q != prev_neg_q) cc_q <= cc_q + CC_W'(1);
				prev_neg_q <= neg_q;
			end
			if (state_q == ST_ACC2) begin
				imag_q <= imag_q + IMAG_W'(prod_q[28:0]);
				if (!frame_end) idx_q <= idx_q + FL_W'(1);
			end
			if (state_q == ST_DMP && div_sts.last) lsel_q <= 1'b0;
			if (state_q == ST_LUPD && k_q == '0) lsel_q <= 1'b1;
			if (state_q == ST_OUT && slot_free) begin
				idx_q <= '0;
				prev_neg_q <= 1'b0;
				tot_q <= '0;
				early_q <= '0;
				mag_acc_q <= '0;
				imag_q <= '0;
				cc_q <= '0;
			end
		end
	end

	// Datapath registers of the shared units.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && in_valid) begin
			mag_q <= mag_in;
			neg_q <= neg_in;
		end
		if (state_q == ST_MEAN && div_sts.last) mean_q <= div_sts.quot[30:0];
		if (state_q == ST_CEN && div_sts.last) qc_q <= div_sts.quot[23:0];
		if (state_q == ST_CFIN) cen_q <= cen_w;
		if (state_q == ST_PH && div_sts.last) ph_q <= ph_w;
		if (state_q == ST_DMP && div_sts.last) begin
			dmp_q <= dmp_w;
			dec_q <= 16'(DEC_SILENT);
			w_q <= early_eps;
			sh_q <= '0;
		end
		if (state_q == ST_LNORM) begin
			if (w_q[LOG_W-1]) begin
				m_q <= w_q[LOG_W-1:LOG_W-MANT_W];
				r_int_q <= LINT_W'(LOG_W - 1) - sh_q;
				r_frac_q <= '0;
				k_q <= 4'd15;
			end else begin
				w_q <= {w_q[LOG_W-2:0], 1'b0};
				sh_q <= sh_q + 6'd1;
			end
		end
		if (state_q == ST_LUPD) begin
			m_q <= m2[31] ? m2[31:1] : m2[30:0];
			r_frac_q <= r_frac_nx;
			k_q <= k_q - 4'd1;
			if (k_q == '0) begin
				r1_q <= r_full;
				d_q <= d_w;
				w_q <= late_eps;
				sh_q <= '0;
			end
		end
		if (state_q == ST_DFIN) dec_q <= dec_w;
		if (state_q == ST_OUT && slot_free) begin
			mean_o_q <= mean_q;
			cen_o_q <= cen_q;
			ph_o_q <= ph_q;
			dec_o_q <= dec_q;
			dmp_o_q <= dmp_q;
		end
	end

	afe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	assign out_valid = out_valid_q;
	assign mean_energy = mean_o_q;
	assign centroid_hz_x16 = cen_o_q;
	assign stability_q16 = ph_o_q;
	assign decay_ms_q10 = dec_o_q;
	assign damping_q16 = dmp_o_q;

endmodule

// ===== design/afe_chk.sv =====
// Port-level checker of the acoustic frame feature extractor and its bind.
module afe_chk import afe_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_wr_en,
	input logic [FL_W-1:0]            cfg_wr_data,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic signed [SAMPLE_W-1:0] sample,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [30:0]                mean_energy,
	input logic [16:0]                centroid_hz_x16,
	input logic [16:0]                stability_q16,
	input logic [15:0]                decay_ms_q10,
	input logic [15:0]                damping_q16
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	// A stalled result keeps its mean, centroid, decay and damping fields.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mean_energy) && $stable(decay_ms_q10)
			&& $stable(damping_q16) && $stable(centroid_hz_x16))
		else $error("result changed under stall");

	// The accumulate cycles after a sample transaction hold off the next one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sample taken during accumulation");

	// Decay and damping stay within their clamps.
	a_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> decay_ms_q10 >= 16'(DEC_MIN) && decay_ms_q10 <= 16'(DEC_MAX)
			&& damping_q16 >= 16'(DMP_MIN) && damping_q16 <= 16'(DMP_MAX))
		else $error("decay or damping out of range");

	// Stability and centroid stay within range.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stability_q16 <= 17'(PH_ONE) && centroid_hz_x16 <= 17'(CEN_MAX))
		else $error("stability or centroid out of range");

endmodule

bind acoustic_frame_feature_extractor_unit afe_chk u_afe_chk (.*);

// ===== sim/tb_acoustic_frame_feature_extractor_unit.sv =====
// Self-checking testbench for the acoustic frame feature extractor unit.
module tb_acoustic_frame_feature_extractor_unit;
	import afe_pkg::*;

	// Kinds of frame content used to build stimulus.
	typedef enum int {
		K_RANDOM,
		K_QUIET,
		K_SILENT,
		K_EARLY_ONLY,
		K_ALT_EXTREME,
		K_LATE_ONLY
	} frame_kind_t;

	// One set of frame features.
	typedef struct {
		logic [30:0] mean_energy;
		logic [16:0] centroid;
		logic [16:0] phase;
		logic [15:0] decay;
		logic [15:0] damping;
	} features_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [FL_W-1:0]            cfg_wr_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_stall;
	logic [30:0]                mean_energy;
	logic [16:0]                centroid_hz_x16;
	logic [16:0]                stability_q16;
	logic [15:0]                decay_ms_q10;
	logic [15:0]                damping_q16;

	acoustic_frame_feature_extractor_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mean_energy     (mean_energy),
		.centroid_hz_x16 (centroid_hz_x16),
		.stability_q16   (stability_q16),
		.decay_ms_q10    (decay_ms_q10),
		.damping_q16     (damping_q16)
	);

	localparam int IDLE_WAIT = 400;
	localparam longint CYCLE_LIMIT = 3000000;

	logic [15:0] pending_samples[$];
	features_t   expected_features[$];
	int          errors = 0;
	longint      cycle_cnt = 0;
	bit          in_taken = 0;

	// Predictor state: register copy and frame accumulators.
	int unsigned     frame_len_reg = 256;
	int unsigned     pos_idx = 0;
	bit              was_neg = 0;
	longint unsigned en_total = 0;
	longint unsigned en_early = 0;
	longint unsigned mag_sum = 0;
	longint unsigned imag_sum = 0;
	int unsigned     xings = 0;

	// Clock.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Truncated log2 in Q.16 by repeated squaring of a normalized mantissa.
	function automatic longint log2_fix(longint unsigned v);
		int p;
		longint unsigned m;
		longint r;
		p = 0;
		if (v == 0) return 0;
		while (p < 63 && (v >> (p + 1)) != 0) p++;
		if (p >= 30) m = v >> (p - 30);
		else m = v << (30 - p);
		r = longint'(p) * 65536;
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r += longint'(1) << k;
			end
		end
		return r;
	endfunction

	// Accumulate one sample; on the last sample of a frame queue its features.
	task automatic accumulate_sample(logic [15:0] raw);
		int unsigned     n;
		bit              neg;
		longint unsigned mag, late, den, rem, q, cen, dmp;
		longint          d, prod, qd, decv;
		features_t       f;
		n = frame_len_reg;
		if (n == 0) n = 1;
		if (n > MAX_FRAME_DEF) n = MAX_FRAME_DEF;
		neg = raw[15];
		mag = neg ? 64'h10000 - 64'(raw) : 64'(raw);
		en_total += mag * mag;
		if (pos_idx < n / 3) en_early += mag * mag;
		mag_sum += mag;
		imag_sum += longint'(pos_idx) * mag;
		if (pos_idx != 0 && neg != was_neg) xings++;
		was_neg = neg;
		if (pos_idx + 1 < n) begin
			pos_idx++;
			return;
		end
		late = en_total - en_early;
		f.mean_energy = 31'((en_total + n / 2) / n);

		// Centroid from a 24-bit fractional quotient.
		if (mag_sum == 0) begin
			cen = 0;
		end else begin
			den = longint'(n) * mag_sum;
			rem = imag_sum;
			q = 0;
			for (int i = 0; i < 24; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= den) begin
					rem -= den;
					q |= 1;
				end
			end
			cen = CEN_BASE + ((CEN_SCALE * q + (64'd1 << 23)) >> 24);
			if (cen > CEN_MAX) cen = CEN_MAX;
		end
		f.centroid = 17'(cen);

		q = (longint'(xings) * 65536 + n / 2) / n;
		f.phase = (q >= 65536) ? 17'd0 : 17'(65536 - q);

		// Decay from the early/late log ratio; fixed when the tail is silent.
		if (late <= EPS) begin
			f.decay = 16'(DEC_SILENT);
		end else begin
			d = log2_fix(en_early + EPS) - log2_fix(late + EPS);
			prod = d * LN2_X24 + (longint'(1) << 21);
			if (prod >= 0) qd = prod >>> 22;
			else qd = -(((-prod) + (longint'(1) << 22) - 1) >>> 22);
			decv = DEC_BASE + qd;
			if (decv < DEC_MIN) decv = DEC_MIN;
			if (decv > DEC_MAX) decv = DEC_MAX;
			f.decay = 16'(decv);
		end

		den = en_total + EPS;
		dmp = (late * 65536 + den / 2) / den;
		if (dmp < DMP_MIN) dmp = DMP_MIN;
		if (dmp > DMP_MAX) dmp = DMP_MAX;
		f.damping = 16'(dmp);
		expected_features.push_back(f);

		pos_idx = 0;
		was_neg = 0;
		en_total = 0;
		en_early = 0;
		mag_sum = 0;
		imag_sum = 0;
		xings = 0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
		errors++;
	endtask

	// Monitor: predicts on accepted samples, checks accepted results.
	always @(posedge clk) begin
		features_t f;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_acoustic_frame_feature_extractor_unit failed");
			$finish;
		end else if (arst_n) begin
			if (cfg_wr_en) frame_len_reg = 32'(cfg_wr_data);
			in_taken = in_valid && !in_stall;
			if (in_taken) accumulate_sample(sample);
			if (out_valid && !out_stall) begin
				if (expected_features.size() == 0) begin
					report_mismatch("unexpected result, mean_energy", mean_energy, 0);
				end else begin
					f = expected_features.pop_front();
					if (mean_energy !== f.mean_energy)
						report_mismatch("mean_energy", mean_energy, f.mean_energy);
					if (centroid_hz_x16 !== f.centroid)
						report_mismatch("centroid_hz_x16", centroid_hz_x16, f.centroid);
					if (stability_q16 !== f.phase)
						report_mismatch("stability_q16", stability_q16, f.phase);
					if (decay_ms_q10 !== f.decay)
						report_mismatch("decay_ms_q10", decay_ms_q10, f.decay);
					if (damping_q16 !== f.damping)
						report_mismatch("damping_q16", damping_q16, f.damping);
				end
			end
		end
	end

	// Driver: offers samples in bursts with random gaps, holding while stalled.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// Transaction still pending; payload stays put.
		end else if (gap_left > 0) begin
			in_valid <= 0;
			gap_left--;
		end else if (pending_samples.size() > 0) begin
			in_valid <= 1;
			sample <= pending_samples.pop_front();
			if (burst_left <= 0) burst_left = $urandom_range(1, 40);
			burst_left--;
			if (burst_left == 0)
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end else begin
			in_valid <= 0;
		end
	end

	// Receiver: stall pattern in modes, plus one long hold-off while samples wait.
	int stall_mode = 0;
	int mode_left = 0;
	int hold_cnt = 0;
	bit hold_done = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 300);
		end
		mode_left--;
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1;
		end else if (!hold_done && out_valid && pending_samples.size() >= 8) begin
			hold_done = 1;
			hold_cnt = 3000;
			out_stall <= 1;
		end else begin
			case (stall_mode)
				0: out_stall <= 0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	function automatic logic [15:0] make_sample(frame_kind_t kind, int pos, int n);
		case (kind)
			K_RANDOM: return 16'($urandom);
			K_QUIET: return 16'($urandom_range(0, 200)) - 16'd100;
			K_SILENT: return 16'd0;
			K_EARLY_ONLY: return (pos < n / 3) ? 16'($urandom) : 16'd0;
			K_ALT_EXTREME: return pos[0] ? 16'h8000 : 16'h7fff;
			default: return (pos < n / 3) ? 16'd0 : 16'($urandom);
		endcase
	endfunction

	// Queue count samples of the given kind for frames of length n.
	task automatic add_samples(frame_kind_t kind, int n, int count);
		int nn;
		nn = (n == 0) ? 1 : (n > MAX_FRAME_DEF ? MAX_FRAME_DEF : n);
		for (int i = 0; i < count; i++) pending_samples.push_back(make_sample(kind, i % nn, nn));
	endtask

	// Let everything drain, then write the frame length.
	task automatic set_frame_length(int unsigned len);
		while (pending_samples.size() != 0 || in_valid || expected_features.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= FL_W'(len);
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	// Stimulus sequence.
	initial begin
		int total;
		int len;
		int nfr;
		int extra;
		frame_kind_t kind;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		in_valid = 0;
		sample = 0;
		out_stall = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes with one-sample frames, then a zero length.
		set_frame_length(1);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'h7fff);
		pending_samples.push_back(16'h0000);
		pending_samples.push_back(16'hffff);
		pending_samples.push_back(16'h0001);
		set_frame_length(0);
		add_samples(K_RANDOM, 0, 2);
		set_frame_length(3);
		add_samples(K_SILENT, 3, 3);
		set_frame_length(6);
		add_samples(K_EARLY_ONLY, 6, 6);
		add_samples(K_LATE_ONLY, 6, 6);
		// Length changed mid-frame to one already passed.
		add_samples(K_ALT_EXTREME, 6, 4);
		set_frame_length(2);
		add_samples(K_RANDOM, 2, 2);
		// A default-sized frame of quiet samples.
		set_frame_length(256);
		add_samples(K_QUIET, 256, 256);
		// Oversized length acts as the maximum frame; shortening it closes the frame.
		set_frame_length(8191);
		add_samples(K_RANDOM, 4096, 120);
		set_frame_length(40);
		add_samples(K_RANDOM, 40, 1);

		// Random phases of short frames with mixed content.
		total = 0;
		while (total < 650) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 48);
			set_frame_length(len);
			nfr = $urandom_range(1, 4);
			for (int k = 0; k < nfr; k++) begin
				kind = frame_kind_t'($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 5));
				add_samples(kind, len, (len == 0) ? 1 : len);
				total += (len == 0) ? 1 : len;
			end
			// Sometimes leave a frame unfinished across the next length change.
			if ($urandom_range(0, 2) == 0) begin
				extra = $urandom_range(1, 5);
				add_samples(K_RANDOM, len, extra);
				total += extra;
			end
		end

		while (pending_samples.size() != 0 || in_valid || expected_features.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("tb_acoustic_frame_feature_extractor_unit passed");
		end else begin
			$display("tb_acoustic_frame_feature_extractor_unit failed");
		end
		$finish;
	end

endmodule
